>>> rtl/axis_rotate_vec4_defines.svh
// ----------------------------------------------------------------------------
// axis_rotate_vec4 assertion macros
// Shared property wrappers for the checker of the vector rotator.
// ----------------------------------------------------------------------------
`ifndef AXIS_ROTATE_VEC4_DEFINES_SVH
`define AXIS_ROTATE_VEC4_DEFINES_SVH

// Property checked out of reset only.
`define ARV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is applied.
`define ARV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/arv_pkg.sv
// ----------------------------------------------------------------------------
// arv_pkg
// Shared constants, types and the CORDIC step-angle table of the rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package arv_pkg;

  // Parameter defaults
  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int TRIG_STAGES_DEF = 16;

  // Trig datapath: Q2.30 sine/cosine, 32-bit turn angle
  localparam int TRIG_W       = 32;
  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // Product split and rounding
  localparam int LO_BITS     = 24;
  localparam int ROUND_SHIFT = 30;

  // Register stages behind the CORDIC
  localparam int MAC_STAGES = 4;

  // atan(2^-i) in 2^32-per-turn units
  localparam logic signed [TRIG_W-1:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef enum logic [1:0] {
    AX_X    = 2'd0,
    AX_Y    = 2'd1,
    AX_Z    = 2'd2,
    AX_NONE = 2'd3
  } axis_code_t;

  // Control carried from the trig pipe into the multiply pipe
  typedef struct packed {
    axis_code_t axis;
    logic       flip;
  } arv_ctl_t;

endpackage

`default_nettype wire

>>> rtl/arv_ifs.sv
// ----------------------------------------------------------------------------
// arv_ifs
// Valid/ready stream interfaces for vector requests and rotated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface arv_in_if #(
  parameter int CW = 32,
  parameter int AW = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           axis;
  logic [AW-1:0]        angle;
  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;
  logic signed [CW-1:0] in_z;
  logic signed [CW-1:0] in_w;

  modport source (output valid, axis, angle, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, axis, angle, in_x, in_y, in_z, in_w, output ready);
endinterface

interface arv_out_if #(
  parameter int CW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic signed [CW-1:0] out_w;

  modport source (output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

`default_nettype wire

>>> rtl/arv_cordic.sv
// ----------------------------------------------------------------------------
// arv_cordic
// Pipelined CORDIC rotator: one micro-rotation per register stage, with the
// vector and axis code riding along beside the trig values.
// ----------------------------------------------------------------------------
`default_nettype none

module arv_cordic #(
  parameter int CW = arv_pkg::COORD_WIDTH_DEF,
  parameter int AW = arv_pkg::ANGLE_WIDTH_DEF,
  parameter int NS = arv_pkg::TRIG_STAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request side
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [1:0]           in_axis,
  input  wire logic [AW-1:0]        in_angle,
  input  wire logic signed [CW-1:0] in_x,
  input  wire logic signed [CW-1:0] in_y,
  input  wire logic signed [CW-1:0] in_z,
  input  wire logic signed [CW-1:0] in_w,
  // trig side
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      arv_pkg::arv_ctl_t    out_ctl,
  output      logic signed [arv_pkg::TRIG_W-1:0] out_cos,
  output      logic signed [arv_pkg::TRIG_W-1:0] out_sin,
  output      logic signed [CW-1:0] out_x,
  output      logic signed [CW-1:0] out_y,
  output      logic signed [CW-1:0] out_z,
  output      logic signed [CW-1:0] out_w
);
  import arv_pkg::*;

  localparam int TW = TRIG_W;

  typedef struct packed {
    arv_ctl_t             ctl;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] w;
  } pay_t;

  // Index k is the input of stage k; index NS is the pipe output
  logic                 v_s   [NS+1];
  logic                 go    [NS+1];
  pay_t                 pay_s [NS+1];
  logic signed [TW-1:0] xs    [NS+1];
  logic signed [TW-1:0] ys    [NS+1];
  logic signed [TW-1:0] zs    [NS+1];

  logic [TW-1:0] a32;
  logic          flip;

  // Fold the angle into [-90, 90) degrees; second and third quadrant flip
  assign a32  = {in_angle, {(TW-AW){1'b0}}};
  assign flip = a32[TW-1] ^ a32[TW-2];

  assign v_s[0]       = in_valid;
  assign pay_s[0].ctl = '{axis: axis_code_t'(in_axis), flip: flip};
  assign pay_s[0].x   = in_x;
  assign pay_s[0].y   = in_y;
  assign pay_s[0].z   = in_z;
  assign pay_s[0].w   = in_w;
  assign xs[0]        = CORDIC_GAIN;
  assign ys[0]        = '0;
  assign zs[0]        = $signed({a32[TW-1] ^ flip, a32[TW-2:0]});

  assign go[NS] = out_ready;

  genvar i;
  for (i = 0; i < NS; i++) begin : g_stage
    logic                 v_r;
    pay_t                 pay_r;
    logic signed [TW-1:0] x_r, y_r, z_r;
    logic signed [TW-1:0] x_nxt, y_nxt, z_nxt;

    // Micro-rotation by atan(2^-i), direction from the residual sign
    always_comb begin
      if (!zs[i][TW-1]) begin
        x_nxt = xs[i] - (ys[i] >>> i);
        y_nxt = ys[i] + (xs[i] >>> i);
        z_nxt = zs[i] - ATAN_TURN32[i];
      end else begin
        x_nxt = xs[i] + (ys[i] >>> i);
        y_nxt = ys[i] - (xs[i] >>> i);
        z_nxt = zs[i] + ATAN_TURN32[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (go[i]) begin
        v_r <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (go[i]) begin
        pay_r <= pay_s[i];
        x_r   <= x_nxt;
        y_r   <= y_nxt;
        z_r   <= z_nxt;
      end
    end

    // Stage moves when empty or when the next one moves
    assign go[i]      = !v_r || go[i+1];
    assign v_s[i+1]   = v_r;
    assign pay_s[i+1] = pay_r;
    assign xs[i+1]    = x_r;
    assign ys[i+1]    = y_r;
    assign zs[i+1]    = z_r;
  end

  assign in_ready  = go[0];
  assign out_valid = v_s[NS];
  assign out_ctl   = pay_s[NS].ctl;
  assign out_cos   = xs[NS];
  assign out_sin   = ys[NS];
  assign out_x     = pay_s[NS].x;
  assign out_y     = pay_s[NS].y;
  assign out_z     = pay_s[NS].z;
  assign out_w     = pay_s[NS].w;

endmodule

`default_nettype wire

>>> rtl/arv_mac.sv
// ----------------------------------------------------------------------------
// arv_mac
// Rotation multiply pipe: operand select, split products, rounded sums,
// then combine, saturate and place into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arv_mac #(
  parameter int CW = arv_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // trig side
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire arv_pkg::arv_ctl_t    in_ctl,
  input  wire logic signed [arv_pkg::TRIG_W-1:0] in_cos,
  input  wire logic signed [arv_pkg::TRIG_W-1:0] in_sin,
  input  wire logic signed [CW-1:0] in_x,
  input  wire logic signed [CW-1:0] in_y,
  input  wire logic signed [CW-1:0] in_z,
  input  wire logic signed [CW-1:0] in_w,
  // result side
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic signed [CW-1:0] out_x,
  output      logic signed [CW-1:0] out_y,
  output      logic signed [CW-1:0] out_z,
  output      logic signed [CW-1:0] out_w
);
  import arv_pkg::*;

  localparam int TW         = TRIG_W;
  localparam int AX_W       = (CW > LO_BITS) ? CW : LO_BITS + 1;
  localparam int PL_W       = TW + LO_BITS + 1;
  localparam int PH_W       = TW + AX_W - LO_BITS;
  localparam int LO_W       = PL_W + 1;
  localparam int HI_W       = PH_W + 1;
  localparam int FW         = HI_W + 1;
  localparam int FRAC_SHIFT = ROUND_SHIFT - LO_BITS;
  localparam logic signed [LO_W-1:0] RND = LO_W'(1) << (ROUND_SHIFT - 1);

  typedef struct packed {
    axis_code_t           axis;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] w;
  } pay_t;

  // Round-shifted combine of high and low partial sums, clamped to CW
  function automatic logic signed [CW-1:0] sat_coord(
    input logic signed [HI_W-1:0] hi,
    input logic signed [LO_W-1:0] lo
  );
    logic signed [FW-1:0] sum;
    logic signed [FW-1:0] sh;
    sum = FW'(hi) + FW'(lo >>> LO_BITS);
    sh  = sum >>> FRAC_SHIFT;
    if (&sh[FW-1:CW-1] || ~|sh[FW-1:CW-1]) begin
      return sh[CW-1:0];
    end else if (sh[FW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  logic go0, go1, go2, go3;

  // Stage 0: operand select
  logic                   v0_r;
  pay_t                   pay0_r;
  logic signed [TW-1:0]   p1_r, q1_r, p2_r, q2_r;
  logic signed [AX_W-1:0] a_r, b_r;
  logic signed [TW-1:0]   cf, sf, nsf;
  logic signed [CW-1:0]   a_sel, b_sel;

  // Stage 1: partial products
  logic                   v1_r;
  pay_t                   pay1_r;
  logic signed [PL_W-1:0] p1al_r, q1bl_r, p2al_r, q2bl_r;
  logic signed [PH_W-1:0] p1ah_r, q1bh_r, p2ah_r, q2bh_r;

  // Stage 2: partial sums
  logic                   v2_r;
  pay_t                   pay2_r;
  logic signed [LO_W-1:0] lo1_r, lo2_r;
  logic signed [HI_W-1:0] hi1_r, hi2_r;

  // Stage 3: output register
  logic                   v3_r;
  logic signed [CW-1:0]   ox_r, oy_r, oz_r, ow_r;
  logic signed [CW-1:0]   ox_nxt, oy_nxt, oz_nxt;
  logic signed [CW-1:0]   r1, r2;

  // Stall chain, output side first
  assign go3      = !v3_r || out_ready;
  assign go2      = !v2_r || go3;
  assign go1      = !v1_r || go2;
  assign go0      = !v0_r || go1;
  assign in_ready = go0;

  // Signed trig terms; a second/third quadrant angle negates cos and sin
  always_comb begin
    cf  = in_ctl.flip ? -in_cos : in_cos;
    sf  = in_ctl.flip ? -in_sin : in_sin;
    nsf = in_ctl.flip ? in_sin : -in_sin;
    a_sel = (in_ctl.axis == AX_X) ? in_y : in_x;
    b_sel = (in_ctl.axis == AX_Z || in_ctl.axis == AX_NONE) ? in_y : in_z;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (go0) v0_r <= in_valid;
      if (go1) v1_r <= v0_r;
      if (go2) v2_r <= v1_r;
      if (go3) v3_r <= v2_r;
    end
  end

  // Stage 0: first output = c*a + q1*b, second = p2*a + c*b
  always_ff @(posedge clk) begin
    if (go0) begin
      pay0_r <= '{axis: in_ctl.axis, x: in_x, y: in_y, z: in_z, w: in_w};
      p1_r   <= cf;
      q1_r   <= (in_ctl.axis == AX_Y) ? sf : nsf;
      p2_r   <= (in_ctl.axis == AX_Y) ? nsf : sf;
      q2_r   <= cf;
      a_r    <= AX_W'(a_sel);
      b_r    <= AX_W'(b_sel);
    end
  end

  // Stage 1: split each coordinate into a low unsigned and a high signed part
  always_ff @(posedge clk) begin
    if (go1) begin
      pay1_r <= pay0_r;
      p1al_r <= p1_r * $signed({1'b0, a_r[LO_BITS-1:0]});
      q1bl_r <= q1_r * $signed({1'b0, b_r[LO_BITS-1:0]});
      p2al_r <= p2_r * $signed({1'b0, a_r[LO_BITS-1:0]});
      q2bl_r <= q2_r * $signed({1'b0, b_r[LO_BITS-1:0]});
      p1ah_r <= p1_r * $signed(a_r[AX_W-1:LO_BITS]);
      q1bh_r <= q1_r * $signed(b_r[AX_W-1:LO_BITS]);
      p2ah_r <= p2_r * $signed(a_r[AX_W-1:LO_BITS]);
      q2bh_r <= q2_r * $signed(b_r[AX_W-1:LO_BITS]);
    end
  end

  // Stage 2: sum the halves, rounding constant added on the low side
  always_ff @(posedge clk) begin
    if (go2) begin
      pay2_r <= pay1_r;
      lo1_r  <= LO_W'(p1al_r) + LO_W'(q1bl_r) + RND;
      lo2_r  <= LO_W'(p2al_r) + LO_W'(q2bl_r) + RND;
      hi1_r  <= HI_W'(p1ah_r) + HI_W'(q1bh_r);
      hi2_r  <= HI_W'(p2ah_r) + HI_W'(q2bh_r);
    end
  end

  // Stage 3: combine, saturate, route to the axes
  always_comb begin
    r1 = sat_coord(hi1_r, lo1_r);
    r2 = sat_coord(hi2_r, lo2_r);
    ox_nxt = pay2_r.x;
    oy_nxt = pay2_r.y;
    oz_nxt = pay2_r.z;
    case (pay2_r.axis)
      AX_X: begin
        oy_nxt = r1;
        oz_nxt = r2;
      end
      AX_Y: begin
        ox_nxt = r1;
        oz_nxt = r2;
      end
      AX_Z: begin
        ox_nxt = r1;
        oy_nxt = r2;
      end
      default: begin
        ox_nxt = pay2_r.x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oz_r <= oz_nxt;
      ow_r <= pay2_r.w;
    end
  end

  assign out_valid = v3_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;
  assign out_w     = ow_r;

endmodule

`default_nettype wire

>>> rtl/axis_rotate_vec4.sv
// A request passes the CORDIC, one micro-rotation per stage, then the
// multiply pipe. Throughput: one request per cycle while the output is
// not stalled; every register stage holds its own valid bit, so bubbles
// close up under output back-pressure; both pipes together set the depth.
// Reset clears only the valid bits; no request is in flight afterwards.
// ----------------------------------------------------------------------------
// axis_rotate_vec4
// Rotates a Q16.16 homogeneous 4-vector about the x, y or z axis by a binary
// angle; axis code three passes the vector through. Results saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_rotate_vec4 #(
  parameter int COORD_WIDTH = arv_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = arv_pkg::ANGLE_WIDTH_DEF,
  parameter int TRIG_STAGES = arv_pkg::TRIG_STAGES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  arv_in_if.sink    in_req,
  arv_out_if.source out_res
);
  import arv_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic                 trig_valid;
  logic                 trig_ready;
  arv_ctl_t             trig_ctl;
  logic signed [TRIG_W-1:0] trig_cos;
  logic signed [TRIG_W-1:0] trig_sin;
  logic signed [CW-1:0] trig_x, trig_y, trig_z, trig_w;

  // Sine and cosine of the request angle
  arv_cordic #(
    .CW (COORD_WIDTH),
    .AW (ANGLE_WIDTH),
    .NS (TRIG_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_axis   (in_req.axis),
    .in_angle  (in_req.angle),
    .in_x      (in_req.in_x),
    .in_y      (in_req.in_y),
    .in_z      (in_req.in_z),
    .in_w      (in_req.in_w),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_ctl   (trig_ctl),
    .out_cos   (trig_cos),
    .out_sin   (trig_sin),
    .out_x     (trig_x),
    .out_y     (trig_y),
    .out_z     (trig_z),
    .out_w     (trig_w)
  );

  // Rotation products, rounding and saturation
  arv_mac #(
    .CW (COORD_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (trig_valid),
    .in_ready  (trig_ready),
    .in_ctl    (trig_ctl),
    .in_cos    (trig_cos),
    .in_sin    (trig_sin),
    .in_x      (trig_x),
    .in_y      (trig_y),
    .in_z      (trig_z),
    .in_w      (trig_w),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_x     (out_res.out_x),
    .out_y     (out_res.out_y),
    .out_z     (out_res.out_z),
    .out_w     (out_res.out_w)
  );

endmodule

`default_nettype wire

>>> rtl/arv_checker.sv
// ----------------------------------------------------------------------------
// arv_checker
// Port-level checks of the rotator: reset, stall behavior and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

`include "axis_rotate_vec4_defines.svh"

module arv_checker #(
  parameter int CW    = arv_pkg::COORD_WIDTH_DEF,
  parameter int DEPTH = arv_pkg::TRIG_STAGES_DEF + arv_pkg::MAC_STAGES
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic signed [CW-1:0] out_x,
  input wire logic signed [CW-1:0] out_y,
  input wire logic signed [CW-1:0] out_z,
  input wire logic signed [CW-1:0] out_w
);
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `ARV_ASSERT_RST(a_rst_clears, !rst_n |=> !out_valid, "result valid after reset")
  `ARV_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_w), "stalled result changed")
  `ARV_ASSERT(a_empty_ready, !out_valid |-> in_ready, "empty output stage but no request taken")
  `ARV_ASSERT(a_no_phantom, out_valid |-> cnt_r != '0, "result without a pending request")
  `ARV_ASSERT(a_depth, cnt_r <= CNT_W'(DEPTH), "more requests in flight than stages")

endmodule

bind axis_rotate_vec4 arv_checker #(
  .CW    (COORD_WIDTH),
  .DEPTH (TRIG_STAGES + arv_pkg::MAC_STAGES)
) u_arv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_x     (out_res.out_x),
  .out_y     (out_res.out_y),
  .out_z     (out_res.out_z),
  .out_w     (out_res.out_w)
);

`default_nettype wire
